>>> rtl/gwyd_pkg.sv
// gwyd_pkg: widths, month tables and helper functions for the gregorian
// weekday and yearday unit
// no dependencies
package gwyd_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned MdayW = 5;
  localparam int unsigned YdayW = 9;
  localparam int unsigned WdayW = 3;
  localparam int unsigned CentW = 8;
  localparam int unsigned YoffW = 7;
  localparam int unsigned DowW = 8;

  // reciprocal of 100 scaled by 2^19, exact for every 14 bit year
  localparam int unsigned RecipShift = 19;
  localparam int unsigned ProdW = YearW + 13;
  localparam logic [ProdW-1:0] Recip100 = ProdW'(5243);
  localparam logic [CentW-1:0] Century = CentW'(100);

  localparam logic [MonthW-1:0] MonthJan = MonthW'(0);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(1);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(11);

  typedef logic [2:0] off_t;
  typedef off_t [3:0] cent_tab_t;
  typedef off_t [11:0] moff_tab_t;
  typedef logic [11:0] [YdayW-1:0] cum_tab_t;

  localparam cent_tab_t CentStart = {3'd6, 3'd0, 3'd2, 3'd4};
  localparam moff_tab_t MoffNormal = {3'd5, 3'd3, 3'd0, 3'd5, 3'd2, 3'd6,
                                      3'd4, 3'd1, 3'd6, 3'd3, 3'd3, 3'd0};
  localparam moff_tab_t MoffLeap = {3'd5, 3'd3, 3'd0, 3'd5, 3'd2, 3'd6,
                                    3'd4, 3'd1, 3'd6, 3'd3, 3'd2, 3'd6};
  // days before each month in a common year
  localparam cum_tab_t CumDays = {9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
                                  9'd151, 9'd120, 9'd90, 9'd59, 9'd31, 9'd0};

  // residue mod 7 by folding base 8 digits, since 8 is 1 mod 7
  function automatic logic [WdayW-1:0] mod7(input logic [DowW-1:0] x);
    logic [4:0] s;
    logic [3:0] t;
    s = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
    t = 4'(s[4:3]) + 4'(s[2:0]);
    if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[WdayW-1:0];
  endfunction

endpackage

>>> rtl/gregorian_weekday_and_yearday_unit.sv
// gregorian_weekday_and_yearday_unit: day of year and day of week of a date
// three register stages: input word, century quotient, result
// depends on gwyd_pkg
// an accepted word passes through the input word, century quotient and result
// registers in that order before its result strobe rises
// throughput: one word per cycle, busy_o stays low, set by the three stage pipe
// the receiver cannot stall; results appear for exactly one cycle
// reset clears the stage valid bits only, data registers are not reset
module gregorian_weekday_and_yearday_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [gwyd_pkg::YearW-1:0]      year_i,
  input  logic [gwyd_pkg::MonthW-1:0]     month_i,
  input  logic [gwyd_pkg::MdayW-1:0]      day_of_month_i,
  output logic                            valid_o,
  output logic [gwyd_pkg::YdayW-1:0]      day_of_year_o,
  output logic [gwyd_pkg::WdayW-1:0]      weekday_o
);
  import gwyd_pkg::*;

  logic                v1_q, v2_q, v3_q;
  logic [YearW-1:0]    year1_q, year2_q;
  logic [MonthW-1:0]   mon1_q, mon2_q;
  logic [MdayW-1:0]    mday1_q, mday2_q;
  logic [CentW-1:0]    cent_d, cent_q;
  logic [ProdW-1:0]    prod;
  logic [YearW-1:0]    yrem;
  logic [YoffW-1:0]    yoff;
  logic                leap;
  logic [1:0]          cidx;
  logic [3:0]          mi;
  logic [2:0]          moff;
  logic [DowW-1:0]     dow;
  logic [YdayW-1:0]    yday_d, yday_q;
  logic [WdayW-1:0]    wday_d, wday_q;

  assign busy_o = 1'b0;

  // stage 1: quotient by 100 via reciprocal multiply
  assign prod   = ProdW'(year1_q) * Recip100;
  assign cent_d = prod[ProdW-1 -: CentW];

  // stage 2: remainder, leap rule, tables, weekday sum
  assign yrem = year2_q - YearW'(cent_q * YearW'(Century));
  assign yoff = yrem[YoffW-1:0];
  assign leap = (year2_q[1:0] == 2'd0) && ((yoff != '0) || (cent_q[1:0] == 2'd0));
  assign cidx = cent_q[1:0] + 2'd3;
  assign mi   = (mon2_q > MonthDec) ? MonthDec : mon2_q;
  assign moff = leap ? MoffLeap[mi] : MoffNormal[mi];

  always_comb begin
    yday_d = CumDays[mi] + YdayW'(mday2_q);
    if (leap && (mi > MonthFeb)) begin
      yday_d = yday_d + YdayW'(1);
    end
    dow = DowW'(CentStart[cidx]) + DowW'(yoff) + DowW'(yoff[YoffW-1:2])
        + DowW'(moff) + DowW'(mday2_q) + DowW'(6);
    wday_d = mod7(dow);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    year1_q <= year_i;
    mon1_q  <= month_i;
    mday1_q <= day_of_month_i;
    year2_q <= year1_q;
    mon2_q  <= mon1_q;
    mday2_q <= mday1_q;
    cent_q  <= cent_d;
    yday_q  <= yday_d;
    wday_q  <= wday_d;
  end

  assign valid_o       = v3_q;
  assign day_of_year_o = yday_q;
  assign weekday_o     = wday_q;

  a_word_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 valid_o)
    else $error("accepted word lost");

  a_result_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(v1_q, 2))
    else $error("result without accepted word");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (weekday_o < WdayW'(7)))
    else $error("weekday out of range");

  a_yday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (day_of_year_o <= YdayW'(366)))
    else $error("day of year out of range");

  a_jan_no_leap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && (mon2_q == MonthJan)) |=> (yday_q == YdayW'($past(mday2_q))))
    else $error("january day of year wrong");

endmodule

>>> dv/tb_gregorian_weekday_and_yearday_unit.sv
`timescale 1ns / 1ps
// tb_gregorian_weekday_and_yearday_unit: self-checking bench for the day of year and
// day of week unit, with directed dates, then random dates, both with random start gaps
// depends on gwyd_pkg and gregorian_weekday_and_yearday_unit
module tb_gregorian_weekday_and_yearday_unit;
  import gwyd_pkg::*;

  localparam int unsigned NumDates = 800;
  localparam int unsigned StallLimit = 200;

  typedef struct packed {
    logic [YdayW-1:0] day_of_year;
    logic [WdayW-1:0] weekday;
  } date_fields_t;

  class date_scoreboard;
    date_fields_t expected_q[$];
    int unsigned faults;
    int unsigned days_before[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int unsigned century_base[4] = '{4, 2, 0, 6};
    int unsigned common_off[12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
    int unsigned leap_off[12] = '{6, 2, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

    static function bit is_leap(input int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function date_fields_t predict_date(input logic [YearW-1:0] y, input logic [MonthW-1:0] m,
                                        input logic [MdayW-1:0] d);
      date_fields_t r;
      logic [MonthW-1:0] mon;
      int unsigned yi, mi, di, yd, yoff, dow;
      bit leap;
      mon = (m > MonthDec) ? MonthDec : m;
      yi = 32'(y);
      mi = 32'(mon);
      di = 32'(d);
      leap = is_leap(yi);
      yd = days_before[mi] + ((leap && mon > MonthFeb) ? 1 : 0) + di;
      yoff = yi % 100;
      dow = century_base[(yi / 100 + 3) % 4] + yoff + yoff / 4
            + (leap ? leap_off[mi] : common_off[mi]) + di + 6;
      r.day_of_year = YdayW'(yd);
      r.weekday = WdayW'(dow % 7);
      return r;
    endfunction

    function void note_date(input logic [YearW-1:0] y, input logic [MonthW-1:0] m,
                            input logic [MdayW-1:0] d);
      expected_q.push_back(predict_date(y, m, d));
    endfunction

    function void check_result(input logic [YdayW-1:0] yd, input logic [WdayW-1:0] wd);
      date_fields_t e;
      if (expected_q.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected result: day_of_year %0d weekday %0d", yd, wd);
        return;
      end
      e = expected_q.pop_front();
      if (yd !== e.day_of_year || wd !== e.weekday) begin
        faults++;
        if (faults <= 10)
          $display("mismatch: day_of_year exp %0d got %0d, weekday exp %0d got %0d",
                   e.day_of_year, yd, e.weekday, wd);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [YearW-1:0]   year_i = '0;
  logic [MonthW-1:0]  month_i = '0;
  logic [MdayW-1:0]   day_of_month_i = '0;
  logic               valid_o;
  logic [YdayW-1:0]   day_of_year_o;
  logic [WdayW-1:0]   weekday_o;

  date_scoreboard sb = new();
  int unsigned stall_cycles = 0;
  bit gaps_on = 1'b1;

  gregorian_weekday_and_yearday_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_of_month_i(day_of_month_i),
    .valid_o       (valid_o),
    .day_of_year_o (day_of_year_o),
    .weekday_o     (weekday_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_ni === 1'b1 && start_i === 1'b1 && busy_o === 1'b0) begin
      sb.note_date(year_i, month_i, day_of_month_i);
      moved = 1'b1;
    end
    if (rst_ni === 1'b1 && valid_o === 1'b1) begin
      sb.check_result(day_of_year_o, weekday_o);
      moved = 1'b1;
    end
    if (moved) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_date(input int unsigned y, input int unsigned m, input int unsigned d);
    start_i <= 1'b1;
    year_i <= YearW'(y);
    month_i <= MonthW'(m);
    day_of_month_i <= MdayW'(d);
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic maybe_gap();
    int unsigned n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 11);
      start_i <= 1'b0;
      year_i <= YearW'($urandom);
      month_i <= MonthW'($urandom);
      day_of_month_i <= MdayW'($urandom);
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    case (m)
      1: return date_scoreboard::is_leap(y) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default: return 31;
    endcase
  endfunction

  task automatic random_date();
    int unsigned kind, y, m, d;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      y = $urandom_range(0, 9999);
      m = $urandom_range(0, 11);
      d = $urandom_range(1, month_days(y, m));
    end else if (kind < 17) begin
      y = $urandom_range(0, 16383);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end else begin
      // century boundaries, with days 27 to 31 of january, february and march
      y = $urandom_range(0, 163) * 100 + $urandom_range(0, 4);
      m = $urandom_range(0, 2);
      d = $urandom_range(27, 31);
    end
    send_date(y, m, d);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    maybe_gap(); send_date(0, 0, 1);
    maybe_gap(); send_date(0, 0, 0);
    maybe_gap(); send_date(16383, 15, 31);
    maybe_gap(); send_date(9999, 11, 31);
    maybe_gap(); send_date(2000, 1, 29);
    maybe_gap(); send_date(1900, 1, 29);
    maybe_gap(); send_date(2024, 2, 1);
    maybe_gap(); send_date(2023, 1, 31);
    maybe_gap(); send_date(2024, 0, 0);
    maybe_gap(); send_date(2023, 2, 0);
    maybe_gap(); send_date(1700, 0, 1);
    maybe_gap(); send_date(1600, 5, 15);
    maybe_gap(); send_date(1599, 11, 31);
    maybe_gap(); send_date(1800, 3, 10);
    maybe_gap(); send_date(12000, 4, 20);
    maybe_gap(); send_date(2021, 12, 5);
    maybe_gap(); send_date(2020, 13, 5);
    maybe_gap(); send_date(2100, 14, 5);
    maybe_gap(); send_date(2400, 15, 5);
    maybe_gap(); send_date(1969, 6, 20);
    maybe_gap(); send_date(1989, 7, 9);
    maybe_gap(); send_date(2001, 8, 11);
    maybe_gap(); send_date(1582, 9, 15);
    maybe_gap(); send_date(1066, 10, 14);

    for (int unsigned i = 0; i < NumDates; i++) begin
      if (i % 50 == 0) gaps_on = (i < NumDates - 100) && ($urandom_range(0, 2) != 0);
      maybe_gap();
      random_date();
    end
    start_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/gwyd_pkg.sv
rtl/gregorian_weekday_and_yearday_unit.sv
dv/tb_gregorian_weekday_and_yearday_unit.sv
